/* design/itrt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_pkg
// Shared types, constants and helper functions for the integer-to-text
// converter.
// ----------------------------------------------------------------------------
package itrt_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;
  localparam int VALUE_W    = 32;
  localparam int BASE_W     = 6;
  localparam int DIGIT_W    = 6;
  localparam int CHAR_W     = 7;
  // quotient bits resolved per divider cycle
  localparam int STEP_BITS  = 8;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO        = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS       = 7'd45;
  localparam logic [CHAR_W-1:0]  CHAR_LETTER_BASE = 7'd55;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX_DEC    = 6'd9;
  localparam logic [BASE_W-1:0]  BASE_MIN         = 6'd2;
  localparam logic [BASE_W-1:0]  BASE_MAX         = 6'd36;

  typedef struct packed {
    logic load;
    logic step;
    logic rd;
    logic sign_sel;
  } itrt_cmd_t;

  typedef struct packed {
    logic step_last;
    logic quot_zero;
    logic count_full;
    logic count_zero;
    logic neg;
  } itrt_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dc;
    dc = CHAR_W'(d);
    if (d > DIGIT_MAX_DEC) begin
      digit_char = dc + CHAR_LETTER_BASE;
    end else begin
      digit_char = dc + CHAR_ZERO;
    end
  endfunction

  function automatic logic [BASE_W-1:0] sat_base(input logic [BASE_W-1:0] b);
    if (b < BASE_MIN) begin
      sat_base = BASE_MIN;
    end else if (b > BASE_MAX) begin
      sat_base = BASE_MAX;
    end else begin
      sat_base = b;
    end
  endfunction

endpackage
`default_nettype wire

/* design/itrt_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/itrt_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_dp
// Datapath: magnitude register, multi-bit-per-cycle restoring divider,
// digit store and character mapping.
// ----------------------------------------------------------------------------
module itrt_dp
  import itrt_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire itrt_cmd_t          cmd,
  output itrt_status_t            status,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic [BASE_W-1:0]  base,
  output logic      [CHAR_W-1:0]  out_char
);

  localparam int DW = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int SC = DW / STEP_BITS;
  localparam int SW = (SC > 1) ? $clog2(SC) : 1;
  localparam int AW = $clog2(VALUE_WIDTH);
  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [DW-1:0]          dvd;
  logic [DIGIT_W-1:0]     rem;
  logic [BASE_W-1:0]      base_r;
  logic                   neg;
  logic [CW-1:0]          cnt;
  logic [SW-1:0]          step;

  logic [VALUE_WIDTH+VALUE_W-1:0] v_ext;
  logic [VALUE_WIDTH-1:0] v;
  logic [VALUE_WIDTH-1:0] mag;
  logic [DW-1:0]          dvd_v;
  logic [DIGIT_W:0]       rem_v;
  logic [CW-1:0]          cnt_m1;
  logic                   step_last;
  logic [DIGIT_W-1:0]     rd_data;

  always_comb begin
    v_ext = {{VALUE_WIDTH{1'b0}}, value};
    v     = v_ext[VALUE_WIDTH-1:0];
    mag   = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
  end

  always_comb begin
    rem_v = {1'b0, rem};
    dvd_v = dvd;
    for (int i = 0; i < STEP_BITS; i++) begin
      rem_v = {rem_v[DIGIT_W-1:0], dvd_v[DW-1]};
      dvd_v = {dvd_v[DW-2:0], 1'b0};
      if (rem_v >= {1'b0, base_r}) begin
        rem_v    = rem_v - {1'b0, base_r};
        dvd_v[0] = 1'b1;
      end
    end
  end

  assign step_last = (step == SW'(SC - 1));
  assign cnt_m1    = cnt - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      step <= '0;
      neg  <= 1'b0;
    end else if (cmd.load) begin
      cnt  <= '0;
      step <= '0;
      neg  <= v[VALUE_WIDTH-1];
    end else if (cmd.step) begin
      if (step_last) begin
        step <= '0;
        cnt  <= cnt + 1'b1;
      end else begin
        step <= step + 1'b1;
      end
    end else if (cmd.rd) begin
      cnt <= cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd    <= DW'(mag);
      rem    <= '0;
      base_r <= sat_base(base);
    end else if (cmd.step) begin
      dvd <= dvd_v;
      rem <= step_last ? '0 : rem_v[DIGIT_W-1:0];
    end
  end

  itrt_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_WIDTH)
  ) u_digits (
    .clk   (clk),
    .we    (cmd.step && step_last),
    .waddr (cnt[AW-1:0]),
    .wdata (rem_v[DIGIT_W-1:0]),
    .re    (cmd.rd),
    .raddr (cnt_m1[AW-1:0]),
    .rdata (rd_data)
  );

  assign out_char = cmd.sign_sel ? CHAR_MINUS : digit_char(rd_data);

  assign status.step_last  = step_last;
  assign status.quot_zero  = (dvd == '0);
  assign status.count_full = (cnt == CW'(VALUE_WIDTH));
  assign status.count_zero = (cnt == '0);
  assign status.neg        = neg;

endmodule
`default_nettype wire

/* design/itrt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_ctrl
// Controller: sequences loading, digit division and character output.
// ----------------------------------------------------------------------------
module itrt_ctrl
  import itrt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic              m_tlast,
  output itrt_cmd_t         cmd,
  input  wire itrt_status_t status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_SHOW = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       conv_done;

  assign conv_done = status.quot_zero || status.count_full;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_SIGN) || (state == S_SHOW);
  assign m_tlast  = (state == S_SHOW) && status.count_zero;

  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.step     = 1'b0;
    cmd.rd       = 1'b0;
    cmd.sign_sel = (state == S_SIGN);
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.step_last) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (conv_done) begin
          cmd.rd     = 1'b1;
          state_next = status.neg ? S_SIGN : S_SHOW;
        end else begin
          state_next = S_DIV;
        end
      end
      S_SIGN: begin
        if (m_tready) begin
          state_next = S_SHOW;
        end
      end
      S_SHOW: begin
        if (m_tready) begin
          if (status.count_zero) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* design/integer_to_radix_text_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_radix_text_top
// Converts a signed integer to its ASCII text in a radix from 2 to 36.
// ----------------------------------------------------------------------------
// Input stream: one word per number, s_tdata[31:0] = value (two's complement),
// s_tdata[37:32] = base (0/1 treated as 2, above 36 treated as 36).
// Output stream: one word per character, most significant first, with a
// leading '-' for negatives; m_tdata[6:0] = ASCII code, m_tlast on the final
// character of each number.
// One number is handled at a time; s_tready is high only while idle.
// Each digit passes through the divider (8 quotient bits per cycle) and a
// check state, then characters go out one per cycle while m_tready is high.
// A stalled receiver holds the current character word; the block waits.
// Reset (rst, synchronous) returns to idle and drops any conversion in flight.
// ----------------------------------------------------------------------------
module integer_to_radix_text_top
  import itrt_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,  // value[31:0], base[37:32], zero pad
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [OUT_DATA_W-1:0] m_tdata,  // character[6:0], zero pad
  output logic                       m_tlast
);

  itrt_cmd_t         cmd;
  itrt_status_t      status;
  logic [CHAR_W-1:0] out_char;

  itrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .status   (status)
  );

  itrt_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .value    (s_tdata[VALUE_W-1:0]),
    .base     (s_tdata[VALUE_W+BASE_W-1:VALUE_W]),
    .out_char (out_char)
  );

  assign m_tdata = {{(OUT_DATA_W-CHAR_W){1'b0}}, out_char};

endmodule
`default_nettype wire

/* design/itrt_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// itrt_checker
// Port-level checks for the integer-to-text converter, bound to the top.
// ----------------------------------------------------------------------------
module itrt_checker
  import itrt_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic                  m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while characters pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !m_tvalid)
    else $error("not busy after accepting a number");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("not idle after final character");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == 8'd45)
      || (m_tdata >= 8'd48 && m_tdata <= 8'd57)
      || (m_tdata >= 8'd65 && m_tdata <= 8'd90))
    else $error("character code out of range");

endmodule

bind integer_to_radix_text_top itrt_checker u_itrt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire

/* test/tb_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer-to-radix-text converter. Numbers go in
// on the slave stream. A local model predicts the character words for each
// accepted number. A checker compares every output word in order against
// that prediction. Directed corner cases come first, then random traffic
// under three back-pressure profiles.
// ----------------------------------------------------------------------------
module tb_top
  import itrt_pkg::*;
();

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // value[31:0], base[37:32], zero pad
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // character[6:0], zero pad
  logic                  m_tlast;

  text_char_t expected_text[$];
  int         send_idle_pct;
  int         recv_idle_pct;
  int         error_count;
  int         numbers_sent;
  int         chars_checked;
  int         negatives_sent;
  int         clamped_bases;

  integer_to_radix_text_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d words still pending",
             CYCLE_LIMIT, expected_text.size());
    $display("** integer_to_radix_text_top: FAILED **");
    $finish;
  end

  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle time %0t: %s got %0d expected %0d", $realtime, what,
             got, want);
    error_count++;
  endtask

  // Expected text: sign, then digits most significant first.
  function automatic void predict_text(input logic [VALUE_W-1:0] value,
                                       input logic [BASE_W-1:0] base);
    logic [BASE_W-1:0]  radix;
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digits[$];
    logic [DIGIT_W-1:0] d;
    text_char_t         tc;
    int                 n;
    radix = base;
    if (radix < BASE_MIN) radix = BASE_MIN;
    if (radix > BASE_MAX) radix = BASE_MAX;
    if (radix != base) clamped_bases++;
    mag = value[VALUE_W-1] ? (~value + 1'b1) : value;
    do begin
      digits.push_back(DIGIT_W'(mag % VALUE_W'(radix)));
      mag = mag / VALUE_W'(radix);
    end while (mag != 0 && digits.size() < VALUE_W);
    if (value[VALUE_W-1]) begin
      tc.character = CHAR_MINUS;
      tc.last = 1'b0;
      expected_text.push_back(tc);
      negatives_sent++;
    end
    for (n = digits.size() - 1; n >= 0; n--) begin
      d = digits[n];
      tc.character = (d > DIGIT_MAX_DEC) ? CHAR_W'(d) + CHAR_LETTER_BASE
                                         : CHAR_W'(d) + CHAR_ZERO;
      tc.last = (n == 0);
      expected_text.push_back(tc);
    end
  endfunction

  task automatic send_number(input logic [VALUE_W-1:0] value, input logic [BASE_W-1:0] base);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata = IN_DATA_W'({$urandom, $urandom});
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {2'b00, base, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_text(value, base);
    numbers_sent++;
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_text.size() == 0) begin
        report_mismatch("unexpected word, character", m_tdata[CHAR_W-1:0], 0);
      end else begin
        if (m_tdata[CHAR_W-1:0] != expected_text[0].character)
          report_mismatch("character", m_tdata[CHAR_W-1:0], expected_text[0].character);
        if (m_tlast != expected_text[0].last)
          report_mismatch("last", m_tlast, expected_text[0].last);
        void'(expected_text.pop_front());
        chars_checked++;
      end
    end
  end

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom_range(40);
      2: v = -VALUE_W'($urandom_range(1, 40));
      3: v = $urandom_range(1) ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
      4: v = $urandom >> $urandom_range(31);
      default: v = -($urandom >> $urandom_range(31));
    endcase
    return v;
  endfunction

  function automatic logic [BASE_W-1:0] random_base();
    if ($urandom_range(9) == 0) return BASE_W'($urandom_range(63));
    return BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
  endfunction

  task automatic test_corner_cases();
    send_number(32'd0, 6'd10);
    send_number(32'd1, 6'd10);
    send_number(-32'sd1, 6'd10);
    send_number(32'h7FFF_FFFF, 6'd2);
    send_number(32'h8000_0000, 6'd2);
    send_number(32'h8000_0000, 6'd10);
    send_number(32'h8000_0000, 6'd36);
    send_number(32'h7FFF_FFFF, 6'd36);
    send_number(-32'sd35, 6'd36);
    send_number(32'd35, 6'd36);
    send_number(32'd10, 6'd11);
    send_number(32'hDEAD_BEEF, 6'd16);
    send_number(-32'sd255, 6'd16);
    send_number(32'd5, 6'd0);
    send_number(-32'sd5, 6'd1);
    send_number(32'd1295, 6'd37);
    send_number(-32'sd1296, 6'd63);
    send_number(32'd0, 6'd0);
    send_number(-32'sd1, 6'd2);
    send_number(32'd123456789, 6'd8);
    send_number(32'h5555_5555, 6'd3);
  endtask

  task automatic test_random_numbers(input int count);
    repeat (count) send_number(random_value(), random_base());
  endtask

  // sender holds off until every pending word has come out
  task automatic test_drain_between_numbers(input int count);
    repeat (count) begin
      send_number(random_value(), random_base());
      wait_for_drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    error_count = 0;
    numbers_sent = 0;
    chars_checked = 0;
    negatives_sent = 0;
    clamped_bases = 0;
    send_idle_pct = 26;
    recv_idle_pct = 77;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_corner_cases();
    test_random_numbers(110);
    send_idle_pct = 77;
    recv_idle_pct = 26;
    test_drain_between_numbers(10);
    test_random_numbers(115);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_numbers(125);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_text.size() != 0)
      report_mismatch("words never received", 0, expected_text.size());

    $display("converted %0d numbers (%0d negative, %0d with clamped base) into %0d words",
             numbers_sent, negatives_sent, clamped_bases, chars_checked);
    $display("traffic ran with heavy output stall, heavy input gaps, then full rate");
    if (error_count == 0) begin
      $display("** integer_to_radix_text_top: PASSED **");
    end else begin
      $display("** integer_to_radix_text_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
design/itrt_pkg.sv
design/itrt_ram.sv
design/itrt_dp.sv
design/itrt_ctrl.sv
design/integer_to_radix_text_top.sv
design/itrt_checker.sv
test/tb_top.sv
